// ----- src/palette_find_or_insert_top_assert.svh -----
// Assertion macros for the palette lookup RTL.
// Needs no package; files that assert include this header by its bare name.
`ifndef PALETTE_FIND_OR_INSERT_TOP_ASSERT_SVH
`define PALETTE_FIND_OR_INSERT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define PFOI_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The expression must never be true outside reset.
`define PFOI_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define PFOI_ASSERT(lbl, clk, rstn, prop, msg)
`define PFOI_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- src/pfoi_pkg.sv -----
// Package for the palette find-or-insert block: codes, types and defaults.
// Depends on nothing; used by every module of the block.
package pfoi_pkg;

	localparam int PALETTE_SIZE_DEF = 256;
	localparam int COLOR_W          = 32;
	localparam int INDEX_W          = 8;
	localparam int STATUS_W         = 2;
	localparam int MEM_ADDR_W       = 8;
	localparam int CFG_INDEX_W      = 8;
	localparam int CFG_DATA_W       = 8;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_BG_Y     = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_U     = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_V     = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_ALPHA = 8'd3;

	// Request from the sequencer to the palette store.
	typedef struct packed {
		logic                  rd_en;
		logic                  wr_en;
		logic [MEM_ADDR_W-1:0] addr;
		logic [COLOR_W-1:0]    wdata;
	} mem_req_t;

	// One result item.
	typedef struct packed {
		logic [INDEX_W-1:0]  index;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ----- src/palette_find_or_insert_top.sv -----
// Palette find-or-insert: maps a YUVA color to a palette index and allocates
// a new entry for a color that has none. A clear, a transparent color (alpha
// zero) or the background color is resolved without a scan; any other color
// is compared with the live entries in order from entry zero until a hit or
// the fill count, and a new color is then appended or reported as full. The
// scan uses a single 32-bit comparator, which checks one stored entry per
// cycle, fed by the one read port of the palette memory. Entries are always
// appended at the lowest empty slot and are never freed one by one, so the
// live entries are exactly those below a fill count; a clear item or reset
// empties the palette at once by zeroing that count, and no clearing pass is
// needed. The input side takes a new transfer as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
// The background registers may be written only while no item is in work.
module palette_find_or_insert_top import pfoi_pkg::*; #(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input items
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [31:0]            s_axis_tdata,  // color_y, color_u, color_v, color_alpha
	input  logic                   s_axis_tuser,  // kind
	// Result items
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [7:0]             m_axis_tdata,  // palette_index
	output logic [STATUS_W-1:0]    m_axis_tuser,  // status
	// Configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int DEPTH = PALETTE_SIZE - 1;
	localparam int AW    = $clog2(PALETTE_SIZE - 1);

	logic [7:0] bg_y_q;
	logic [7:0] bg_u_q;
	logic [7:0] bg_v_q;
	logic [7:0] bg_alpha_q;

	logic               res_valid;
	logic               res_ready;
	result_t            res;
	mem_req_t           mem_req;
	logic [COLOR_W-1:0] rd_data;
	logic [COLOR_W-1:0] in_color;

	logic               out_valid_q;
	result_t            out_q;

	// Colors are compared in one packed word: y, u, v, alpha from the top.
	assign in_color = {s_axis_tdata[7:0], s_axis_tdata[15:8],
		s_axis_tdata[23:16], s_axis_tdata[31:24]};

	// Background registers. Writes to an index beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_y_q     <= '0;
			bg_u_q     <= '0;
			bg_v_q     <= '0;
			bg_alpha_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BG_Y:     bg_y_q     <= cfg_data;
				REG_BG_U:     bg_u_q     <= cfg_data;
				REG_BG_V:     bg_v_q     <= cfg_data;
				REG_BG_ALPHA: bg_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pfoi_ctrl #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_color (in_color),
		.bg_color ({bg_y_q, bg_u_q, bg_v_q, bg_alpha_q}),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_req  (mem_req),
		.rd_data  (rd_data)
	);

	pfoi_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.req    (mem_req),
		.rd_data(rd_data)
	);

	// Output register: the sequencer hands over a result whenever this
	// register is empty or is being emptied by a transfer in the same cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.index;
	assign m_axis_tuser  = out_q.status;

endmodule

// ----- src/pfoi_store.sv -----
// Palette entry store: single-port memory with a registered read.
// Depends on pfoi_pkg for the request type.
module pfoi_store import pfoi_pkg::*; #(
	parameter int DEPTH = PALETTE_SIZE_DEF - 1,
	parameter int AW    = $clog2(PALETTE_SIZE_DEF - 1)
) (
	input  logic               clk,
	input  mem_req_t           req,
	output logic [COLOR_W-1:0] rd_data
);

	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] rd_data_s1;

	// Contents need no reset: the fill count decides which entries are live.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

// ----- src/pfoi_ctrl.sv -----
// Sequencer of the palette lookup: classifies an item, scans the live
// entries through one comparator and appends new colors. Uses pfoi_pkg.
module pfoi_ctrl import pfoi_pkg::*; #(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_kind,
	input  logic [COLOR_W-1:0] in_color,
	input  logic [COLOR_W-1:0] bg_color,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res,
	output mem_req_t           mem_req,
	input  logic [COLOR_W-1:0] rd_data
);

	`include "palette_find_or_insert_top_assert.svh"

	localparam int REGULAR_COUNT = PALETTE_SIZE - 1;
	localparam int AW            = $clog2(REGULAR_COUNT);
	localparam int CW            = $clog2(PALETTE_SIZE);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	localparam logic [INDEX_W-1:0] BG_INDEX = INDEX_W'(PALETTE_SIZE - 1);

	logic [1:0]         state_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      scan_q;
	logic [AW-1:0]      idx_s1;
	logic               rd_valid_s1;
	logic [COLOR_W-1:0] color_q;
	result_t            res_q;

	logic issue;
	logic hit;
	logic scan_end;
	logic room;

	// Entries below the fill count are live; allocation always appends.
	assign issue    = scan_q < fill_q;
	assign hit      = rd_valid_s1 && (rd_data == color_q);
	assign scan_end = !hit && !issue && !rd_valid_s1;
	assign room     = fill_q < CW'(REGULAR_COUNT);

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = color_q;
		if (state_q == S_SCAN) begin
			if (scan_end) begin
				mem_req.wr_en = room;
				mem_req.addr  = MEM_ADDR_W'(fill_q);
			end else begin
				mem_req.rd_en = issue && !hit;
				mem_req.addr  = MEM_ADDR_W'(scan_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_kind) begin
							fill_q  <= '0;
							state_q <= S_DONE;
						end else if (in_color[7:0] == 8'd0 || in_color == bg_color) begin
							state_q <= S_DONE;
						end else begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						rd_valid_s1 <= 1'b0;
						state_q     <= S_DONE;
					end else if (scan_end) begin
						if (room) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						rd_valid_s1 <= issue;
						if (issue) begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			color_q <= in_color;
			if (in_kind) begin
				res_q <= '{index: '0, status: ST_CLEARED};
			end else begin
				res_q <= '{index: BG_INDEX, status: ST_FOUND};
			end
		end else if (state_q == S_SCAN) begin
			idx_s1 <= scan_q[AW-1:0];
			if (hit) begin
				res_q <= '{index: INDEX_W'(idx_s1), status: ST_FOUND};
			end else if (scan_end) begin
				if (room) begin
					res_q <= '{index: INDEX_W'(fill_q), status: ST_INSERTED};
				end else begin
					res_q <= '{index: '0, status: ST_FULL};
				end
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	`PFOI_ASSERT(a_fill_bound, clk, arst_n, fill_q <= CW'(REGULAR_COUNT), "fill count overran the palette")
	`PFOI_ASSERT(a_scan_bound, clk, arst_n, (state_q == S_SCAN) |-> (scan_q <= fill_q), "scan passed the fill count")
	`PFOI_ASSERT(a_write_grows, clk, arst_n, mem_req.wr_en |=> (fill_q == $past(fill_q) + 1'b1), "append did not advance the fill count")
	`PFOI_ASSERT_NEVER(a_idle_read, clk, arst_n, (state_q == S_IDLE) && rd_valid_s1, "read left in flight outside a scan")

endmodule

// ----- tb/tb_palette_find_or_insert_top.sv -----
// Self-checking testbench for palette_find_or_insert_top: directed and random color traffic
// checked against a cycle-free model of the palette kept inside this file.
// Depends on pfoi_pkg for status codes, register indexes and the result type.
`timescale 1ns / 100ps

module tb_palette_find_or_insert_top;
	import pfoi_pkg::*;

	localparam int PALETTE_SIZE = PALETTE_SIZE_DEF;
	localparam logic [INDEX_W-1:0] BG_INDEX = INDEX_W'(PALETTE_SIZE - 1);
	// Longest item is a full scan plus pipeline overhead.
	localparam int SETTLE_CYCLES = PALETTE_SIZE + 8;
	// Length of the deliberate output hold-off.
	localparam int BACKLOG_CYCLES = 500;
	// Cycles without any transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int POOL_DEPTH = 40;
	localparam int PHASE_ITEMS = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // color_y, color_u, color_v, color_alpha
	logic s_axis_tuser = 1'b0;  // kind
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;  // palette_index
	logic [STATUS_W-1:0] m_axis_tuser;  // status
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the palette and the background registers.
	logic [COLOR_W-1:0] palette_copy [PALETTE_SIZE-1] = '{default: '0};
	logic [7:0] bg_y = '0;
	logic [7:0] bg_u = '0;
	logic [7:0] bg_v = '0;
	logic [7:0] bg_alpha = '0;

	// Expected results in transfer order, oldest first.
	result_t pending_results[$];
	// Recently used colors, so that random traffic hits existing entries.
	logic [31:0] color_pool[$];

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit backlog_req = 1'b0;
	int rx_stall = 0;
	int rx_hold = 0;
	int quiet_cycles = 0;

	int mismatch_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int status_seen [4] = '{default: 0};
	int bg_settings = 1;

	always #5 clk = ~clk;

	palette_find_or_insert_top #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Computes the result of one item and updates the shadow palette. The color word
	// uses the tdata layout: y in the low byte, alpha in the high byte.
	function automatic result_t resolve_color(input bit clear_req, input logic [31:0] word);
		result_t res;
		logic [31:0] bg_word;
		res.index = '0;
		res.status = ST_FOUND;
		bg_word = {bg_alpha, bg_v, bg_u, bg_y};
		if (clear_req) begin
			foreach (palette_copy[slot]) palette_copy[slot] = '0;
			res.status = ST_CLEARED;
			return res;
		end
		// A transparent color, or the background color itself, maps to the last index.
		if (word[31:24] == 8'h00 || word == bg_word) begin
			res.index = BG_INDEX;
			return res;
		end
		// Empty entries are all zero and can never equal a color with nonzero alpha.
		foreach (palette_copy[slot]) begin
			if (palette_copy[slot] == word) begin
				res.index = INDEX_W'(slot);
				return res;
			end
		end
		foreach (palette_copy[slot]) begin
			if (palette_copy[slot] == '0) begin
				palette_copy[slot] = word;
				res.index = INDEX_W'(slot);
				res.status = ST_INSERTED;
				return res;
			end
		end
		res.status = ST_FULL;
		return res;
	endfunction

	// Compares one result transfer with the oldest expectation.
	function automatic void check_result(input logic [7:0] got_index, input logic [1:0] got_status);
		result_t want;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("ERROR: result with nothing expected: index %0d status %0d",
					got_index, got_status);
			return;
		end
		want = pending_results.pop_front();
		results_seen++;
		status_seen[want.status]++;
		if (got_index !== want.index || got_status !== want.status) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("ERROR: result %0d: expected index %0d status %0d, got index %0d status %0d",
					results_seen, want.index, want.status, got_index, got_status);
		end
	endfunction

	// Result side. Every accepted transfer is checked here; afterwards the receiver may
	// stall at random. A hold-off request drops tready for a long stretch so that
	// the block backs up and stops taking input.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_result(m_axis_tdata, m_axis_tuser);
			rx_stall = rx_idle_en ? $urandom_range(0, 6) : 0;
		end
		if (backlog_req) begin
			backlog_req = 1'b0;
			rx_hold = BACKLOG_CYCLES;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles", quiet_cycles);
			$display("palette_find_or_insert_top verification failed");
			$finish;
		end
	end

	// Offers one item and waits for its transfer. Valid stays high after the transfer,
	// so back-to-back items never lower and raise it within one time step.
	task automatic send_item(input bit clear_req, input logic [31:0] word);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= clear_req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(resolve_color(clear_req, word));
		items_sent++;
	endtask

	// Drops valid and waits until every expected result has arrived.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// One register write; valid is left high for the caller to lower.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BG_Y: bg_y = value;
			REG_BG_U: bg_u = value;
			REG_BG_V: bg_v = value;
			REG_BG_ALPHA: bg_alpha = value;
			default: ;
		endcase
	endtask

	// Loads all four background registers. Only called with the block idle.
	task automatic load_background(input logic [7:0] y, input logic [7:0] u,
			input logic [7:0] v, input logic [7:0] a);
		write_reg(REG_BG_Y, y);
		write_reg(REG_BG_U, u);
		write_reg(REG_BG_V, v);
		write_reg(REG_BG_ALPHA, a);
		cfg_valid <= 1'b0;
		bg_settings++;
	endtask

	// Draws one random item from a mix of clears, transparent colors, background hits,
	// near misses of the background, reused colors and fresh colors.
	task automatic send_random_item(input int clear_pct);
		int pick;
		logic [31:0] word;
		pick = $urandom_range(0, 99);
		word = $urandom();
		if (pick < clear_pct)
			send_item(1'b1, word);
		else if (pick < clear_pct + 10)
			send_item(1'b0, {8'h00, word[23:0]});
		else if (pick < clear_pct + 18)
			send_item(1'b0, {bg_alpha, bg_v, bg_u, bg_y});
		else if (pick < clear_pct + 22)
			send_item(1'b0, {bg_alpha, bg_v, bg_u, bg_y} ^ (32'h1 << $urandom_range(0, 31)));
		else if (pick < clear_pct + 67 && color_pool.size() > 0)
			send_item(1'b0, color_pool[$urandom_range(0, color_pool.size() - 1)]);
		else begin
			color_pool.push_back(word);
			if (color_pool.size() > POOL_DEPTH)
				void'(color_pool.pop_front());
			send_item(1'b0, word);
		end
	endtask

	// Right after reset the background registers are zero and the palette is empty.
	task automatic test_transparent_after_reset();
		send_item(1'b0, 32'h00FF_FFFF);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h0100_0000);
		send_item(1'b0, {8'h00, 24'($urandom())});
		drain_results();
	endtask

	// A color equal to the background resolves to the last index; one bit off is a
	// regular color. Covers the all-one register values and zero y, u and v values.
	task automatic test_background_match();
		load_background(8'h12, 8'h34, 8'h56, 8'h78);
		send_item(1'b0, 32'h7856_3412);
		send_item(1'b0, 32'h7856_3413);
		send_item(1'b0, 32'hF856_3412);
		send_item(1'b0, 32'h7856_3413);
		drain_results();
		load_background(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'hFEFF_FFFF);
		drain_results();
		load_background(8'h00, 8'h00, 8'h00, 8'h01);
		send_item(1'b0, 32'h0100_0000);
		drain_results();
	endtask

	// Writes to indexes past the last register must leave the background untouched.
	task automatic test_unused_register();
		write_reg(8'hFF, 8'hFF);
		write_reg(CFG_INDEX_W'($urandom_range(4, 254)), 8'($urandom()));
		write_reg(8'h04, 8'h00);
		cfg_valid <= 1'b0;
		send_item(1'b0, 32'h0100_0000);
		send_item(1'b0, {bg_alpha, bg_v, bg_u, bg_y});
		drain_results();
	endtask

	// A clear ignores its color fields, and allocation restarts at index zero.
	task automatic test_clear_item();
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h8080_8080);
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b0, 32'h4000_0000);
		drain_results();
	endtask

	// Fills every regular entry, then checks the full status, a hit on the last entry
	// and recovery through a clear.
	task automatic test_palette_full();
		load_background(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'h00);
		send_item(1'b1, 32'h0000_0000);
		// The alpha byte keeps every color distinct.
		for (int n = 1; n < PALETTE_SIZE; n++)
			send_item(1'b0, {8'(n), 24'($urandom())});
		send_item(1'b0, 32'h0000_0001 ^ {8'h80, 24'($urandom())});
		send_item(1'b0, palette_copy[PALETTE_SIZE-2]);
		send_item(1'b0, palette_copy[0]);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b0, 32'hFF00_00FF);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering items
	// without gaps, so the block fills and stalls its input.
	task automatic test_output_backpressure();
		tx_idle_en = 1'b0;
		backlog_req = 1'b1;
		for (int n = 0; n < 16; n++)
			send_random_item(2);
		drain_results();
		tx_idle_en = 1'b1;
	endtask

	// Random phases, each under its own background setting. Some phases never clear,
	// so the palette keeps growing through them.
	// Idling is switched on and off in blocks of fifty items.
	task automatic test_random_traffic();
		int clear_pct [6] = '{2, 0, 0, 1, 0, 3};
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_background(8'h00, 8'h00, 8'h00, 8'h00);
				1: load_background(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				2: load_background(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'h01);
				3: load_background(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'h00);
				default: load_background(8'($urandom()), 8'($urandom()), 8'($urandom()),
					8'($urandom()));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				tx_idle_en = ((n / 50) % 2) == 0;
				rx_idle_en = ((n / 50 + phase) % 2) == 0;
				send_random_item(clear_pct[phase]);
			end
			drain_results();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_transparent_after_reset();
		test_background_match();
		test_unused_register();
		test_clear_item();
		test_palette_full();
		test_output_backpressure();
		test_random_traffic();

		// Give the block time for any stray result after the last expected one.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count += pending_results.size();
			$display("ERROR: %0d expected results never arrived", pending_results.size());
		end

		$display("Resolved %0d items under %0d background settings: %0d found, %0d inserted,",
			items_sent, bg_settings, status_seen[ST_FOUND], status_seen[ST_INSERTED]);
		$display("%0d full, %0d cleared; %0d mismatches.",
			status_seen[ST_FULL], status_seen[ST_CLEARED], mismatch_count);
		if (mismatch_count == 0)
			$display("palette_find_or_insert_top verification clean");
		else
			$display("palette_find_or_insert_top verification failed");
		$finish;
	end

endmodule
